// File: hdl/kle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kle_pkg
// Shared types and constants of the keystroke line editor: key codes, the
// controller state encoding and the command/status bundles.
// ----------------------------------------------------------------------------
package kle_pkg;

   localparam logic [7:0] KEY_BACK = 8'd60;
   localparam logic [7:0] KEY_HOME = 8'd91;
   localparam logic [7:0] KEY_END  = 8'd93;
   localparam logic [7:0] NEWLINE  = 8'd10;

   typedef enum logic [8:0] {
      ST_IDLE       = 9'b000000001,
      ST_INS_READ   = 9'b000000010,
      ST_INS_LINK   = 9'b000000100,
      ST_INS_SPLICE = 9'b000001000,
      ST_DEL_READ   = 9'b000010000,
      ST_DEL_UNLINK = 9'b000100000,
      ST_WALK_READ  = 9'b001000000,
      ST_WALK_EMIT  = 9'b010000000,
      ST_WALK_NL    = 9'b100000000
   } kle_state_type;

   typedef struct packed {
      logic take_item;
      logic set_home;
      logic set_end;
      logic set_overflow;
      logic ins_read;
      logic ins_link;
      logic ins_splice;
      logic del_read;
      logic del_unlink;
      logic walk_start;
      logic walk_read;
      logic walk_emit;
      logic emit_newline;
   } kle_cmd_type;

   typedef struct packed {
      logic line_end;
      logic key_back;
      logic key_home;
      logic key_end;
      logic cursor_at_head;
      logic pool_full;
      logic walk_empty;
      logic next_is_end;
      logic out_free;
   } kle_status_type;

endpackage
`default_nettype wire

// File: hdl/kle_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kle_req_if
// Keystroke channel: one keystroke or end-of-line word per handshake.
// ----------------------------------------------------------------------------
interface kle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] key_byte;
   logic       line_end;

   modport source (output valid, output key_byte, output line_end, input ready);
   modport sink   (input valid, input key_byte, input line_end, output ready);
endinterface
`default_nettype wire

// File: hdl/kle_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kle_rsp_if
// Result channel: one character word of the finished line per handshake.
// ----------------------------------------------------------------------------
interface kle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic       overflow;

   modport source (output valid, output out_byte, output out_last, output overflow,
                   input ready);
   modport sink   (input valid, input out_byte, input out_last, input overflow,
                   output ready);
endinterface
`default_nettype wire

// File: hdl/kle_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kle_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hdl/kle_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kle_ctrl
// Controller of the line editor: decodes each keystroke word and sequences
// the link memory accesses of inserts, deletes and the end-of-line walk.
// ----------------------------------------------------------------------------
module kle_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire kle_pkg::kle_status_type status,
   output kle_pkg::kle_cmd_type         cmd
);
   import kle_pkg::*;

   kle_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               priority if (status.line_end) begin
                  cmd.walk_start = 1'b1;
                  state_in = status.walk_empty ? ST_WALK_NL : ST_WALK_READ;
               end else if (status.key_back) begin
                  // Backspace with the cursor on the head does nothing.
                  if (!status.cursor_at_head) begin
                     state_in = ST_DEL_READ;
                  end
               end else if (status.key_home) begin
                  cmd.set_home = 1'b1;
               end else if (status.key_end) begin
                  cmd.set_end = 1'b1;
               end else if (status.pool_full) begin
                  cmd.set_overflow = 1'b1;
               end else begin
                  state_in = ST_INS_READ;
               end
            end
         end
         ST_INS_READ: begin
            cmd.ins_read = 1'b1;
            state_in = ST_INS_LINK;
         end
         ST_INS_LINK: begin
            cmd.ins_link = 1'b1;
            state_in = ST_INS_SPLICE;
         end
         ST_INS_SPLICE: begin
            cmd.ins_splice = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DEL_READ: begin
            cmd.del_read = 1'b1;
            state_in = ST_DEL_UNLINK;
         end
         ST_DEL_UNLINK: begin
            cmd.del_unlink = 1'b1;
            state_in = ST_IDLE;
         end
         ST_WALK_READ: begin
            cmd.walk_read = 1'b1;
            state_in = ST_WALK_EMIT;
         end
         ST_WALK_EMIT: begin
            if (status.out_free) begin
               cmd.walk_emit = 1'b1;
               state_in = status.next_is_end ? ST_WALK_NL : ST_WALK_READ;
            end
         end
         ST_WALK_NL: begin
            if (status.out_free) begin
               cmd.emit_newline = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: hdl/kle_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kle_datapath
// Line storage and pointers: character, next and previous link memories,
// the cursor, tail and allocation registers, and the result register.
// ----------------------------------------------------------------------------
module kle_datapath #(
   parameter int NODES = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire kle_pkg::kle_cmd_type    cmd,
   output kle_pkg::kle_status_type      status,
   input  wire logic [7:0]              req_key_byte,
   input  wire logic                    req_line_end,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_out_last,
   output logic                         rsp_overflow
);
   import kle_pkg::*;

   localparam int SlotW  = $clog2(NODES);
   localparam int AllocW = $clog2(NODES + 1);

   logic [SlotW-1:0]  cursor_ff, tail_ff, head_next_ff, walk_ff, after_ff;
   logic [AllocW-1:0] alloc_ff;
   logic              overflow_ff;
   logic [7:0]        key_ff;
   logic              out_valid_ff;
   logic [7:0]        out_byte_ff;
   logic              out_last_ff;
   logic              out_overflow_ff;

   logic [SlotW-1:0]  slot;
   logic [SlotW-1:0]  after_now;
   logic              cursor_zero;
   logic              out_free;

   logic              char_we, next_we, prev_we, next_re;
   logic [SlotW-1:0]  next_wa, next_wd, prev_wa, prev_wd, next_ra;
   logic [7:0]        char_rd;
   logic [SlotW-1:0]  next_rd, prev_rd;

   assign slot        = alloc_ff[SlotW-1:0];
   assign cursor_zero = (cursor_ff == '0);
   // The head's successor lives in a register; slot 0 of the next memory is unused.
   assign after_now   = cursor_zero ? head_next_ff : next_rd;
   assign out_free    = !out_valid_ff || rsp_ready;

   always_comb begin
      status                = '0;
      status.line_end       = req_line_end;
      status.key_back       = (req_key_byte == KEY_BACK);
      status.key_home       = (req_key_byte == KEY_HOME);
      status.key_end        = (req_key_byte == KEY_END);
      status.cursor_at_head = cursor_zero;
      status.pool_full      = (alloc_ff >= AllocW'(NODES));
      status.walk_empty     = (head_next_ff == '0);
      status.next_is_end    = (next_rd == '0);
      status.out_free       = out_free;
   end

   // Memory port steering.
   assign char_we = cmd.ins_link;
   assign next_re = cmd.ins_read || cmd.del_read || cmd.walk_read;
   assign next_ra = cmd.walk_read ? walk_ff : cursor_ff;

   always_comb begin
      next_we = 1'b0;
      next_wa = slot;
      next_wd = after_now;
      prev_we = 1'b0;
      prev_wa = slot;
      prev_wd = cursor_ff;
      priority if (cmd.ins_link) begin
         next_we = 1'b1;
         prev_we = 1'b1;
      end else if (cmd.ins_splice) begin
         next_we = !cursor_zero;
         next_wa = cursor_ff;
         next_wd = slot;
         prev_we = (after_ff != '0);
         prev_wa = after_ff;
         prev_wd = slot;
      end else if (cmd.del_unlink) begin
         next_we = (prev_rd != '0);
         next_wa = prev_rd;
         next_wd = next_rd;
         prev_we = (next_rd != '0);
         prev_wa = next_rd;
         prev_wd = prev_rd;
      end
   end

   kle_ram #(.WIDTH(8), .DEPTH(NODES)) u_char_ram (
      .clock   (clock),
      .wr_en   (char_we),
      .wr_addr (slot),
      .wr_data (key_ff),
      .rd_en   (cmd.walk_read),
      .rd_addr (walk_ff),
      .rd_data (char_rd)
   );

   kle_ram #(.WIDTH(SlotW), .DEPTH(NODES)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_en   (next_re),
      .rd_addr (next_ra),
      .rd_data (next_rd)
   );

   kle_ram #(.WIDTH(SlotW), .DEPTH(NODES)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_en   (cmd.del_read),
      .rd_addr (cursor_ff),
      .rd_data (prev_rd)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         tail_ff      <= '0;
         head_next_ff <= '0;
         alloc_ff     <= AllocW'(1);
         overflow_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.set_home) begin
            cursor_ff <= '0;
         end
         if (cmd.set_end) begin
            cursor_ff <= tail_ff;
         end
         if (cmd.set_overflow) begin
            overflow_ff <= 1'b1;
         end
         if (cmd.ins_splice) begin
            if (cursor_zero) begin
               head_next_ff <= slot;
            end
            if (after_ff == '0) begin
               tail_ff <= slot;
            end
            cursor_ff <= slot;
            alloc_ff  <= alloc_ff + AllocW'(1);
         end
         if (cmd.del_unlink) begin
            if (prev_rd == '0) begin
               head_next_ff <= next_rd;
            end
            if (cursor_ff == tail_ff) begin
               tail_ff <= prev_rd;
            end
            cursor_ff <= prev_rd;
         end
         if (cmd.emit_newline) begin
            cursor_ff    <= '0;
            tail_ff      <= '0;
            head_next_ff <= '0;
            alloc_ff     <= AllocW'(1);
         end
         if (cmd.walk_emit || cmd.emit_newline) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         key_ff <= req_key_byte;
      end
      if (cmd.ins_link) begin
         after_ff <= after_now;
      end
      if (cmd.walk_start) begin
         walk_ff <= head_next_ff;
      end else if (cmd.walk_emit) begin
         walk_ff <= next_rd;
      end
      if (cmd.walk_emit) begin
         out_byte_ff     <= char_rd;
         out_last_ff     <= 1'b0;
         out_overflow_ff <= overflow_ff;
      end else if (cmd.emit_newline) begin
         out_byte_ff     <= NEWLINE;
         out_last_ff     <= 1'b1;
         out_overflow_ff <= overflow_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_out_last = out_last_ff;
   assign rsp_overflow = out_overflow_ff;

`ifndef SYNTHESIS
   a_alloc_bound: assert property (@(posedge clock) disable iff (reset)
      alloc_ff <= AllocW'(NODES))
      else $error("allocation pointer ran past the node pool");

   a_cursor_allocated: assert property (@(posedge clock) disable iff (reset)
      AllocW'(cursor_ff) < alloc_ff)
      else $error("cursor stands on a slot that was never allocated");

   a_tail_allocated: assert property (@(posedge clock) disable iff (reset)
      AllocW'(tail_ff) < alloc_ff)
      else $error("tail stands on a slot that was never allocated");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("overflow flag cleared without reset");

   a_line_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_newline |=> (alloc_ff == AllocW'(1)) && (head_next_ff == '0))
      else $error("line not cleared after the newline word");
`endif

endmodule
`default_nettype wire

// File: hdl/keystroke_line_editor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keystroke_line_editor_unit
// Cursor line editor on a doubly linked list held in node memories.
// ----------------------------------------------------------------------------
// Each request word is one keystroke: '<' deletes the character before the
// cursor, '[' and ']' move the cursor home and to the end, and any other byte
// is inserted after the cursor. A word with line_end set walks the line and
// returns every character followed by a newline word marked last, then clears
// the line. Home, end, ignored backspaces and dropped inserts finish in the
// accepting state; a backspace then steps through a read and an unlink state,
// an insert through a read, a link and a splice state, set by the registered
// read of the link memories and their single write port. The line end reads
// and emits each character in turn, as each step reads the next link before
// it can follow it, and stalls while a result waits. The line holds up to
// NODES-1 characters; further inserts are dropped and raise a sticky overflow
// bit carried on every result word. No memory clearing pass follows reset.
// ----------------------------------------------------------------------------
module keystroke_line_editor_unit #(
   parameter int NODES = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   kle_req_if.sink   req_chan,
   kle_rsp_if.source rsp_chan
);
   import kle_pkg::*;

   kle_cmd_type    cmd;
   kle_status_type status;

   kle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   kle_datapath #(.NODES(NODES)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_key_byte (req_chan.key_byte),
      .req_line_end (req_chan.line_end),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .rsp_out_byte (rsp_chan.out_byte),
      .rsp_out_last (rsp_chan.out_last),
      .rsp_overflow (rsp_chan.overflow)
   );

endmodule
`default_nettype wire
